/* rtl/strq_pkg.sv */
package strq_pkg;

	localparam int DATA_W     = 32;
	localparam int POS_W      = 10;
	localparam int RANGE_W    = 11;
	localparam int LEAVES_DEF = 1024;

	localparam logic [DATA_W-1:0] MAX_IDENTITY = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] SUM_IDENTITY = '0;

	localparam logic KIND_SET   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic MODE_SUM = 1'b0;
	localparam logic MODE_MAX = 1'b1;

	function automatic logic [DATA_W-1:0] identity_of(input logic mode);
		return (mode == MODE_MAX) ? MAX_IDENTITY : SUM_IDENTITY;
	endfunction

	// wrapping sum or signed maximum; both commute, so operand order is free
	function automatic logic [DATA_W-1:0] combine(input logic mode,
			input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
		if (mode == MODE_MAX)
			return ($signed(a) >= $signed(b)) ? a : b;
		return a + b;
	endfunction

endpackage

/* rtl/strq_ram.sv */
module strq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/segment_tree_range_query.sv */
// Bottom-up segment tree over LEAVES leaves, kept in one 2*LEAVES x 32 synchronous RAM with
// one write and one read port. A set request writes its leaf and then walks up to the root,
// reading one sibling and writing one parent per cycle. A query request folds
// [range_lo, range_hi) level by level, issuing at most one node read per cycle, as the RAM
// has a single read port. The result sits in an output register, so the next request is
// taken while it waits. After reset and after every op_mode write the RAM is swept to the
// identity of the new mode, during which in_stall stays high.
module segment_tree_range_query import strq_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [POS_W-1:0]          position,
	input  logic signed [DATA_W-1:0]  value,
	input  logic [RANGE_W-1:0]        range_lo,
	input  logic [RANGE_W-1:0]        range_hi,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  fold_value
);

	localparam int DEPTH  = 2 * LEAVES;
	localparam int NODE_W = $clog2(DEPTH);
	// query bounds reach 2*LEAVES, one past the last node
	localparam int PTR_W  = NODE_W + 1;
	localparam int CMP_W  = (PTR_W > RANGE_W) ? PTR_W : RANGE_W;

	localparam logic [CMP_W-1:0]  LEAVES_C  = CMP_W'(LEAVES);
	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(DEPTH - 1);
	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_UPD   = 2'd2;
	localparam logic [1:0] ST_QRY   = 2'd3;

	localparam logic SIDE_L = 1'b0;
	localparam logic SIDE_R = 1'b1;

	logic [1:0]        state_q;
	logic [NODE_W-1:0] clr_q;
	logic              op_mode_q;

	// update walk
	logic [NODE_W-1:0] cur_q;
	logic [DATA_W-1:0] carry_q;

	// query walk
	logic [PTR_W-1:0]  lo_q;
	logic [PTR_W-1:0]  hi_q;
	logic              ldone_q;
	logic [DATA_W-1:0] acc_l_q;
	logic [DATA_W-1:0] acc_r_q;
	logic              pend_s1;
	logic              side_s1;

	logic              out_valid_q;
	logic [DATA_W-1:0] fold_q;

	// RAM port
	logic              mem_we;
	logic [NODE_W-1:0] mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [NODE_W-1:0] mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	logic              in_acc;
	logic [CMP_W-1:0]  pos_ext;
	logic              pos_ok;
	logic [CMP_W-1:0]  leaf_sum;
	logic [NODE_W-1:0] leaf_node;
	logic [CMP_W-1:0]  lo_ext;
	logic [CMP_W-1:0]  hi_ext;
	logic [CMP_W-1:0]  lo_sat;
	logic [CMP_W-1:0]  hi_sat;
	logic [CMP_W-1:0]  lo_sum;
	logic [CMP_W-1:0]  hi_sum;

	logic [NODE_W-1:0] par;
	logic [DATA_W-1:0] upd_val;

	logic              q_active;
	logic              need_l;
	logic              need_r;
	logic [PTR_W-1:0]  hi_m1;
	logic [PTR_W-1:0]  lo_adv;
	logic [PTR_W-1:0]  hi_adv;
	logic              out_free;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign fold_value = fold_q;
	// output slot is free when empty or being taken this cycle
	assign out_free   = !out_valid_q || !out_stall;

	// leaf address for a set request; positions past the last leaf are dropped
	assign pos_ext   = CMP_W'(position);
	assign pos_ok    = pos_ext < LEAVES_C;
	assign leaf_sum  = pos_ext + LEAVES_C;
	assign leaf_node = leaf_sum[NODE_W-1:0];

	// saturate range bounds to the leaf count, then move them to node space
	assign lo_ext = CMP_W'(range_lo);
	assign hi_ext = CMP_W'(range_hi);
	assign lo_sat = (lo_ext > LEAVES_C) ? LEAVES_C : lo_ext;
	assign hi_sat = (hi_ext > LEAVES_C) ? LEAVES_C : hi_ext;
	assign lo_sum = lo_sat + LEAVES_C;
	assign hi_sum = hi_sat + LEAVES_C;

	// update step: parent gets the carried child combined with the sibling just read
	assign par     = cur_q >> 1;
	assign upd_val = combine(op_mode_q, carry_q, mem_rdata);

	// query step: left node when lo is odd, right node when hi is odd, then go up a level
	assign q_active = lo_q < hi_q;
	assign need_l   = lo_q[0] && !ldone_q;
	assign need_r   = hi_q[0];
	assign hi_m1    = hi_q - PTR_W'(1);
	assign lo_adv   = (lo_q >> 1) + PTR_W'(lo_q[0]);
	assign hi_adv   = hi_q >> 1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = identity_of(op_mode_q);
			end
			ST_IDLE: begin
				// write the leaf and fetch its sibling in the same cycle
				if (in_acc && kind == KIND_SET && pos_ok) begin
					mem_we    = 1'b1;
					mem_waddr = leaf_node;
					mem_wdata = value;
					mem_re    = 1'b1;
					mem_raddr = leaf_node ^ NODE_W'(1);
				end
			end
			ST_UPD: begin
				mem_we    = 1'b1;
				mem_waddr = par;
				mem_wdata = upd_val;
				if (par != ROOT_NODE) begin
					mem_re    = 1'b1;
					mem_raddr = par ^ NODE_W'(1);
				end
			end
			ST_QRY: begin
				if (q_active) begin
					if (need_l) begin
						mem_re    = 1'b1;
						mem_raddr = lo_q[NODE_W-1:0];
					end else if (need_r) begin
						mem_re    = 1'b1;
						mem_raddr = hi_m1[NODE_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	strq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_nodes (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			op_mode_q   <= MODE_SUM;
			ldone_q     <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == LAST_NODE)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (kind == KIND_QUERY) begin
							ldone_q <= 1'b0;
							pend_s1 <= 1'b0;
							state_q <= ST_QRY;
						end else if (pos_ok) begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					if (par == ROOT_NODE)
						state_q <= ST_IDLE;
				end
				ST_QRY: begin
					pend_s1 <= 1'b0;
					if (q_active) begin
						if (need_l) begin
							pend_s1 <= 1'b1;
							// stay on this level when the right node is still due
							ldone_q <= need_r;
						end else begin
							pend_s1 <= need_r;
							ldone_q <= 1'b0;
						end
					end else if (!pend_s1 && out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// a mode write restarts the sweep with the new identity
			if (cfg_we) begin
				op_mode_q <= cfg_data;
				clr_q     <= '0;
				state_q   <= ST_CLEAR;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cur_q   <= leaf_node;
				carry_q <= value;
				lo_q    <= lo_sum[PTR_W-1:0];
				hi_q    <= hi_sum[PTR_W-1:0];
				acc_l_q <= identity_of(op_mode_q);
				acc_r_q <= identity_of(op_mode_q);
			end
			ST_UPD: begin
				cur_q   <= par;
				carry_q <= upd_val;
			end
			ST_QRY: begin
				// fold the node read last cycle into its side
				if (pend_s1) begin
					if (side_s1 == SIDE_L)
						acc_l_q <= combine(op_mode_q, acc_l_q, mem_rdata);
					else
						acc_r_q <= combine(op_mode_q, mem_rdata, acc_r_q);
				end
				if (q_active) begin
					side_s1 <= need_l ? SIDE_L : SIDE_R;
					// advance one level unless the right node is still due
					if (!(need_l && need_r)) begin
						lo_q <= lo_adv;
						hi_q <= hi_adv;
					end
				end else if (!pend_s1 && out_free) begin
					fold_q <= combine(op_mode_q, acc_l_q, acc_r_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
